FILE: src/kpsr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpsr_pkg
// Shared types and constants of the keypad scanner with release detection.
// ----------------------------------------------------------------------------
package kpsr_pkg;

  localparam int CMD_W      = 2;
  localparam int ROWS_W     = 16;
  localparam int DIRECT_W   = 4;
  localparam int CODE_W     = 5;
  localparam int PERIOD_W   = 8;

  localparam int ROWS_PER_COL        = 4;
  localparam int SNAP_COLS           = 4;
  localparam int MATRIX_COLS_DEFAULT = 4;

  localparam logic [CMD_W-1:0] CMD_MATRIX = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DIRECT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

  localparam logic [CODE_W-1:0]   CODE_NONE    = 5'd0;
  localparam logic [CODE_W-1:0]   DIRECT_BASE  = 5'd17;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd20;

  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic [ROWS_W-1:0]   matrix_rows;
    logic [DIRECT_W-1:0] direct_keys;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } stage_t;

endpackage

FILE: src/kpsr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpsr_if
// Valid/ready channels of the keypad scanner: request, result, configuration.
// ----------------------------------------------------------------------------
interface kpsr_in_if;
  logic                          valid;
  logic                          ready;
  logic [kpsr_pkg::CMD_W-1:0]    command;
  logic [kpsr_pkg::ROWS_W-1:0]   matrix_rows;
  logic [kpsr_pkg::DIRECT_W-1:0] direct_keys;

  modport source (output valid, command, matrix_rows, direct_keys, input ready);
  modport sink   (input valid, command, matrix_rows, direct_keys, output ready);
endinterface

interface kpsr_out_if;
  logic                        valid;
  logic                        ready;
  logic [kpsr_pkg::CODE_W-1:0] key_code;

  modport source (output valid, key_code, input ready);
  modport sink   (input valid, key_code, output ready);
endinterface

interface kpsr_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [kpsr_pkg::PERIOD_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

FILE: src/kpsr_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpsr_in_stage
// Input register that holds one request until the core takes it.
// ----------------------------------------------------------------------------
module kpsr_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  kpsr_pkg::item_t   in_item,
  input  logic              advance,
  output kpsr_pkg::stage_t  stage
);

  logic            valid_r, valid_nxt;
  kpsr_pkg::item_t item_r, item_nxt;
  logic            load;

  assign in_ready = !valid_r || advance;
  assign load     = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (load) begin
      valid_nxt = 1'b1;
      item_nxt  = in_item;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    item_r <= item_nxt;
  end

  assign stage.valid = valid_r;
  assign stage.item  = item_r;

endmodule

FILE: src/kpsr_encode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpsr_encode
// Priority encoders that turn a matrix snapshot or direct lines into a code.
// ----------------------------------------------------------------------------
module kpsr_encode #(
  parameter int MATRIX_COLS = kpsr_pkg::MATRIX_COLS_DEFAULT
) (
  input  logic [kpsr_pkg::ROWS_W-1:0]   matrix_rows,
  input  logic [kpsr_pkg::DIRECT_W-1:0] direct_keys,
  output logic [kpsr_pkg::CODE_W-1:0]   matrix_code,
  output logic [kpsr_pkg::CODE_W-1:0]   direct_code
);

  localparam int ACTIVE_COLS =
    (MATRIX_COLS < kpsr_pkg::SNAP_COLS) ? MATRIX_COLS : kpsr_pkg::SNAP_COLS;

  always_comb begin
    logic [kpsr_pkg::CODE_W-1:0] col_code;
    logic                        col_hit;
    matrix_code = kpsr_pkg::CODE_NONE;
    for (int c = 0; c < ACTIVE_COLS; c++) begin
      col_code = kpsr_pkg::CODE_NONE;
      col_hit  = 1'b0;
      for (int r = kpsr_pkg::ROWS_PER_COL - 1; r >= 0; r--) begin
        if (!matrix_rows[c * kpsr_pkg::ROWS_PER_COL + r]) begin
          col_code = kpsr_pkg::CODE_W'(c * kpsr_pkg::ROWS_PER_COL + r + 1);
          col_hit  = 1'b1;
        end
      end
      if (col_hit) begin
        matrix_code = col_code;
      end
    end
  end

  always_comb begin
    direct_code = kpsr_pkg::CODE_NONE;
    for (int k = kpsr_pkg::DIRECT_W - 1; k >= 0; k--) begin
      if (!direct_keys[k]) begin
        direct_code = kpsr_pkg::DIRECT_BASE + kpsr_pkg::CODE_W'(k);
      end
    end
  end

endmodule

FILE: src/kpsr_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpsr_core
// Tick dividers, sample history, pending key and the result register.
// ----------------------------------------------------------------------------
module kpsr_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  kpsr_pkg::stage_t              stage,
  input  logic [kpsr_pkg::CODE_W-1:0]   matrix_code,
  input  logic [kpsr_pkg::CODE_W-1:0]   direct_code,
  output logic                          advance,
  input  logic                          cfg_valid,
  input  logic [kpsr_pkg::PERIOD_W-1:0] cfg_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [kpsr_pkg::CODE_W-1:0]   out_key_code
);

  localparam int CW = kpsr_pkg::CODE_W;
  localparam int PW = kpsr_pkg::PERIOD_W;

  logic [PW-1:0] period_r, period_nxt;
  logic [PW-1:0] mdiv_r, mdiv_nxt, ddiv_r, ddiv_nxt;
  logic [CW-1:0] mcur_r, mcur_nxt, mprev_r, mprev_nxt;
  logic [CW-1:0] dcur_r, dcur_nxt, dprev_r, dprev_nxt;
  logic [CW-1:0] pend_r, pend_nxt;
  logic          oval_r, oval_nxt;
  logic [CW-1:0] okey_r, okey_nxt;

  logic          out_free;
  logic          is_read;
  logic [PW:0]   mdiv_inc, ddiv_inc;
  logic          mdue, ddue;

  assign is_read  = (stage.item.command == kpsr_pkg::CMD_READ);
  assign out_free = !oval_r || out_ready;
  assign advance  = stage.valid && (!is_read || out_free);

  assign mdiv_inc = {1'b0, mdiv_r} + (PW+1)'(1);
  assign ddiv_inc = {1'b0, ddiv_r} + (PW+1)'(1);
  assign mdue     = (mdiv_inc >= {1'b0, period_r});
  assign ddue     = (ddiv_inc >= {1'b0, period_r});

  always_comb begin
    period_nxt = cfg_valid ? cfg_data : period_r;
    mdiv_nxt   = mdiv_r;
    ddiv_nxt   = ddiv_r;
    mcur_nxt   = mcur_r;
    mprev_nxt  = mprev_r;
    dcur_nxt   = dcur_r;
    dprev_nxt  = dprev_r;
    pend_nxt   = pend_r;
    oval_nxt   = oval_r && !out_ready;
    okey_nxt   = okey_r;
    if (advance) begin
      case (stage.item.command)
        kpsr_pkg::CMD_MATRIX: begin
          mdiv_nxt = mdue ? '0 : mdiv_inc[PW-1:0];
          if (mdue) begin
            mprev_nxt = mcur_r;
            mcur_nxt  = matrix_code;
            if (matrix_code == kpsr_pkg::CODE_NONE && mcur_r != kpsr_pkg::CODE_NONE) begin
              pend_nxt = mcur_r;
            end
          end
        end
        kpsr_pkg::CMD_DIRECT: begin
          ddiv_nxt = ddue ? '0 : ddiv_inc[PW-1:0];
          if (ddue) begin
            dprev_nxt = dcur_r;
            dcur_nxt  = direct_code;
            if (direct_code == kpsr_pkg::CODE_NONE && dcur_r != kpsr_pkg::CODE_NONE) begin
              pend_nxt = dcur_r;
            end
          end
        end
        kpsr_pkg::CMD_READ: begin
          oval_nxt = 1'b1;
          okey_nxt = pend_r;
          pend_nxt = kpsr_pkg::CODE_NONE;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= kpsr_pkg::PERIOD_RESET;
      mdiv_r   <= '0;
      ddiv_r   <= '0;
      mcur_r   <= '0;
      mprev_r  <= '0;
      dcur_r   <= '0;
      dprev_r  <= '0;
      pend_r   <= '0;
      oval_r   <= 1'b0;
    end else begin
      period_r <= period_nxt;
      mdiv_r   <= mdiv_nxt;
      ddiv_r   <= ddiv_nxt;
      mcur_r   <= mcur_nxt;
      mprev_r  <= mprev_nxt;
      dcur_r   <= dcur_nxt;
      dprev_r  <= dprev_nxt;
      pend_r   <= pend_nxt;
      oval_r   <= oval_nxt;
    end
    okey_r <= okey_nxt;
  end

  assign out_valid    = oval_r;
  assign out_key_code = okey_r;

endmodule

FILE: src/keypad_scan_release_detect.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_scan_release_detect
// Matrix and direct keypad scanner that reports the last released key.
// ----------------------------------------------------------------------------
// Every request is registered on input and completed from that register,
// so one request per clock is taken when the result side keeps up. Ticks
// produce no result; a read produces one key code through an output register,
// and a read waits in the input register only while that register is still
// full and not being taken. Configuration writes are accepted every cycle.
module keypad_scan_release_detect #(
  parameter int MATRIX_COLS = kpsr_pkg::MATRIX_COLS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst_n,
  kpsr_in_if.sink    in_ch,
  kpsr_out_if.source out_ch,
  kpsr_cfg_if.sink   cfg_ch
);

  kpsr_pkg::item_t             in_item;
  kpsr_pkg::stage_t            stage;
  logic                        advance;
  logic [kpsr_pkg::CODE_W-1:0] matrix_code;
  logic [kpsr_pkg::CODE_W-1:0] direct_code;

  assign in_item.command     = in_ch.command;
  assign in_item.matrix_rows = in_ch.matrix_rows;
  assign in_item.direct_keys = in_ch.direct_keys;
  assign cfg_ch.ready        = 1'b1;

  kpsr_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_item  (in_item),
    .advance  (advance),
    .stage    (stage)
  );

  kpsr_encode #(
    .MATRIX_COLS (MATRIX_COLS)
  ) u_encode (
    .matrix_rows (stage.item.matrix_rows),
    .direct_keys (stage.item.direct_keys),
    .matrix_code (matrix_code),
    .direct_code (direct_code)
  );

  kpsr_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .stage        (stage),
    .matrix_code  (matrix_code),
    .direct_code  (direct_code),
    .advance      (advance),
    .cfg_valid    (cfg_ch.valid),
    .cfg_data     (cfg_ch.data),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_key_code (out_ch.key_code)
  );

endmodule
